// ----- hw/rtl/utf8ld_pkg.sv -----
// Package for the lenient UTF-8 decoder: sequencer states, byte class
// constants and the lead-byte decode function. No dependencies.

package utf8ld_pkg;

    localparam int unsigned HOLD_DEPTH = 5;
    localparam int unsigned CP_W       = 31;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned IDX_W      = 3;

    localparam logic [7:0] LEAD_MIN   = 8'hC0;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD5_MIN  = 8'hF8;
    localparam logic [7:0] LEAD6_MIN  = 8'hFC;
    localparam logic [7:0] RAW_HI_MIN = 8'hFE;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;

    localparam logic [CNT_W-1:0] ONE_BYTE = 3'd1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_FLUSH = 5'b00100,
        S_FRESH = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic [4:0]       bits;
    } t_lead;

    function automatic logic is_raw(input logic [7:0] b);
        return (b < LEAD_MIN) || (b >= RAW_HI_MIN);
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    function automatic t_lead lead_decode(input logic [7:0] b);
        t_lead r;
        if (b < LEAD3_MIN) begin
            r.len  = 3'd2;
            r.bits = b[4:0];
        end else if (b < LEAD4_MIN) begin
            r.len  = 3'd3;
            r.bits = {1'b0, b[3:0]};
        end else if (b < LEAD5_MIN) begin
            r.len  = 3'd4;
            r.bits = {2'b0, b[2:0]};
        end else if (b < LEAD6_MIN) begin
            r.len  = 3'd5;
            r.bits = {3'b0, b[1:0]};
        end else begin
            r.len  = 3'd6;
            r.bits = {4'b0, b[0]};
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/utf8_lenient_decoder_unit.sv -----
// Lenient UTF-8 decoder top level: byte stream in, code point stream out.
// Depends on utf8ld_pkg.
//
// Usage:
//   Slave channel s_axis: one raw byte per beat in tdata[7:0], tlast marks
//   the last byte of the data. Master channel m_axis: one code point per
//   beat, tdata[30:0] = code_point, tdata[33:31] = byte_count, upper bits
//   zero; tlast marks the last result caused by one input byte.
//   A byte that only opens or extends a sequence gives no result. A broken
//   or unterminated sequence returns each held byte raw, one beat each.
//   Timing: a byte is taken in the idle state and decoded in the next cycle;
//   the sequencer then forms each result in turn as the output register
//   frees, and a lead byte opens its sequence in the fresh-byte state. The
//   longest run for one byte is five held bytes broken by a lead byte
//   flagged as end of data. Results are registered: they appear in the
//   output register in the cycle after they are formed.
//   Reset: synchronous, active low; clears the open sequence and output valid.
//   Stall: while the output is full and m_axis_tready is low the sequencer
//   holds on its next result; a new byte is still taken once it is idle.

module utf8_lenient_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [30:0] code_point, [33:31] byte_count, [39:34] 0
    output logic        m_axis_tlast    // last_of_run
);

    localparam int unsigned CP_W  = utf8ld_pkg::CP_W;
    localparam int unsigned CNT_W = utf8ld_pkg::CNT_W;
    localparam int unsigned IDX_W = utf8ld_pkg::IDX_W;
    localparam logic [CNT_W-1:0] ONE = utf8ld_pkg::ONE_BYTE;

    utf8ld_pkg::t_state r_state, n_state;

    logic [7:0]       r_byte;
    logic             r_eod;
    logic             r_fresh, n_fresh;
    logic [7:0]       r_held [utf8ld_pkg::HOLD_DEPTH];
    logic [CNT_W-1:0] r_held_cnt, n_held_cnt;
    logic [CNT_W-1:0] r_exp_len, n_exp_len;
    logic [CP_W-1:0]  r_partial, n_partial;
    logic [IDX_W-1:0] r_idx, n_idx;

    logic             r_out_valid, n_out_valid;
    logic [CP_W-1:0]  r_out_cp, n_out_cp;
    logic [CNT_W-1:0] r_out_cnt, n_out_cnt;
    logic             r_out_last, n_out_last;

    logic             accept;
    logic             out_free;
    logic             held_we;
    logic [IDX_W-1:0] held_wa;
    logic             fresh_emits;
    logic             flush_end;
    utf8ld_pkg::t_lead lead;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == utf8ld_pkg::S_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign lead          = utf8ld_pkg::lead_decode(r_byte);
    assign fresh_emits   = utf8ld_pkg::is_raw(r_byte) || r_eod;
    assign flush_end     = (r_idx == (r_held_cnt - ONE));

    always_comb begin
        n_state     = r_state;
        n_fresh     = r_fresh;
        n_held_cnt  = r_held_cnt;
        n_exp_len   = r_exp_len;
        n_partial   = r_partial;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_cp    = r_out_cp;
        n_out_cnt   = r_out_cnt;
        n_out_last  = r_out_last;
        held_we     = 1'b0;
        held_wa     = r_held_cnt;
        case (r_state)
            utf8ld_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = utf8ld_pkg::S_EVAL;
                end
            end
            utf8ld_pkg::S_EVAL: begin
                n_idx = '0;
                if (r_held_cnt == '0) begin
                    n_state = utf8ld_pkg::S_FRESH;
                end else if (utf8ld_pkg::is_cont(r_byte)) begin
                    held_we    = (r_held_cnt < CNT_W'(utf8ld_pkg::HOLD_DEPTH));
                    n_held_cnt = r_held_cnt + ONE;
                    n_partial  = {r_partial[CP_W-7:0], r_byte[5:0]};
                    if (n_held_cnt >= r_exp_len) begin
                        n_state = utf8ld_pkg::S_EMIT;
                    end else if (r_eod) begin
                        n_fresh = 1'b0;
                        n_state = utf8ld_pkg::S_FLUSH;
                    end else begin
                        n_state = utf8ld_pkg::S_IDLE;
                    end
                end else begin
                    n_fresh = 1'b1;
                    n_state = utf8ld_pkg::S_FLUSH;
                end
            end
            utf8ld_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_cp    = r_partial;
                    n_out_cnt   = r_exp_len;
                    n_out_last  = 1'b1;
                    n_held_cnt  = '0;
                    n_exp_len   = '0;
                    n_partial   = '0;
                    n_state     = utf8ld_pkg::S_IDLE;
                end
            end
            utf8ld_pkg::S_FLUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_cp    = CP_W'(r_held[r_idx]);
                    n_out_cnt   = ONE;
                    n_out_last  = flush_end && !(r_fresh && fresh_emits);
                    n_idx       = r_idx + IDX_W'(1);
                    if (flush_end) begin
                        n_held_cnt = '0;
                        n_exp_len  = '0;
                        n_partial  = '0;
                        n_idx      = '0;
                        n_state    = r_fresh ? utf8ld_pkg::S_FRESH : utf8ld_pkg::S_IDLE;
                    end
                end
            end
            utf8ld_pkg::S_FRESH: begin
                n_fresh = 1'b0;
                if (utf8ld_pkg::is_raw(r_byte)) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_cp    = CP_W'(r_byte);
                        n_out_cnt   = ONE;
                        n_out_last  = 1'b1;
                        n_state     = utf8ld_pkg::S_IDLE;
                    end
                end else begin
                    held_we    = 1'b1;
                    held_wa    = '0;
                    n_held_cnt = ONE;
                    n_exp_len  = lead.len;
                    n_partial  = CP_W'(lead.bits);
                    n_idx      = '0;
                    n_state    = r_eod ? utf8ld_pkg::S_FLUSH : utf8ld_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = utf8ld_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= utf8ld_pkg::S_IDLE;
            r_fresh     <= 1'b0;
            r_held_cnt  <= '0;
            r_exp_len   <= '0;
            r_partial   <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fresh     <= n_fresh;
            r_held_cnt  <= n_held_cnt;
            r_exp_len   <= n_exp_len;
            r_partial   <= n_partial;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= s_axis_tdata;
            r_eod  <= s_axis_tlast;
        end
        if (held_we) begin
            r_held[held_wa] <= r_byte;
        end
        r_out_cp   <= n_out_cp;
        r_out_cnt  <= n_out_cnt;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_cnt, r_out_cp};
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_held_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_cnt != '0 && r_state == utf8ld_pkg::S_IDLE) |-> (r_held_cnt < r_exp_len))
        else $error("open sequence already complete while idle");

    a_flush_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == utf8ld_pkg::S_FLUSH) |-> (r_idx < r_held_cnt))
        else $error("flush index beyond held bytes");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == utf8ld_pkg::S_EVAL))
        else $error("accepted byte not evaluated");

    a_idle_empty_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_cnt == '0) |-> (r_exp_len == '0))
        else $error("length set with no open sequence");
`endif

endmodule
